// ===== sv/v4mu_pkg.sv =====
package v4mu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Operation codes.
    localparam logic [1:0] FUNC_MAG   = 2'd0;
    localparam logic [1:0] FUNC_NORM  = 2'd1;
    localparam logic [1:0] FUNC_DOT   = 2'd2;
    localparam logic [1:0] FUNC_CROSS = 2'd3;

    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 56;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_w;
        logic signed [31:0] res_scalar;
        logic               fault;
    } t_out_word;

    // Clamp a signed 68-bit value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -68'sh0_0000_0000_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== sv/v4mu_lane.sv =====
// One lane: squares and products of one component, registered.
module v4mu_lane (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_c,
    input  logic signed [31:0] i_d,
    output logic [63:0]        o_sq,
    output logic signed [63:0] o_ab,
    output logic signed [63:0] o_cd
);
    logic [63:0]        r_sq;
    logic signed [63:0] r_ab;
    logic signed [63:0] r_cd;

    // Three products per lane, one register stage.
    always_ff @(posedge i_clk) begin
        r_sq <= 64'(i_a * i_a);
        r_ab <= i_a * i_b;
        r_cd <= i_c * i_d;
    end

    assign o_sq = r_sq;
    assign o_ab = r_ab;
    assign o_cd = r_cd;
endmodule

// ===== sv/v4mu_sqrt_stage.sv =====
// One step of the restoring square root, pipelined.
module v4mu_sqrt_stage #(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic [65:0] i_rem,
    input  logic [32:0] i_root,
    input  logic [64:0] i_n,
    output logic [65:0] o_rem,
    output logic [32:0] o_root,
    output logic [64:0] o_n
);
    localparam int SH = 2 * (32 - STEP);
    logic [65:0] n_rem;
    logic [65:0] n_trial;

    // Bring down two bits and try root*4+1.
    always_comb begin
        n_rem   = {i_rem[63:0], 2'(i_n >> SH)};
        n_trial = {31'd0, i_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (n_rem >= n_trial) begin
            o_rem  <= n_rem - n_trial;
            o_root <= {i_root[31:0], 1'b1};
        end else begin
            o_rem  <= n_rem;
            o_root <= {i_root[31:0], 1'b0};
        end
        o_n <= i_n;
    end
endmodule

// ===== sv/v4mu_div_stage.sv =====
// One step of a restoring divider, pipelined; numerator and divisor ride along.
module v4mu_div_stage #(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic [56:0] i_rem,
    input  logic [55:0] i_q,
    input  logic [55:0] i_num,
    input  logic [32:0] i_den,
    output logic [56:0] o_rem,
    output logic [55:0] o_q,
    output logic [55:0] o_num,
    output logic [32:0] o_den
);
    localparam int BIT = 55 - STEP;
    logic [56:0] n_rem;

    always_comb begin
        n_rem = {i_rem[55:0], i_num[BIT]};
    end

    always_ff @(posedge i_clk) begin
        if (n_rem >= {24'd0, i_den}) begin
            o_rem <= n_rem - {24'd0, i_den};
            o_q   <= i_q | (56'd1 << BIT);
        end else begin
            o_rem <= n_rem;
            o_q   <= i_q;
        end
        o_num <= i_num;
        o_den <= i_den;
    end
endmodule

// ===== sv/vector4_math_unit.sv =====
// Channel  | direction | handshake          | word
// ---------+-----------+--------------------+-------------------------
// command  | in        | i_start, o_busy    | i_cmd (v4mu_pkg::t_in_word)
// result   | out       | o_done strobe      | o_res (v4mu_pkg::t_out_word)
//
// One word is accepted every cycle; o_busy stays low.
// Each word passes the product stage, the merge stage, the 33-step root pipeline,
// the 56-step divider pipeline that normalize needs, and the output register.
// Synchronous active-low reset clears the valid chain only.
// The receiver takes each result in the cycle of its o_done strobe.
module vector4_math_unit #(
    parameter int FRAC_BITS = v4mu_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  v4mu_pkg::t_in_word   i_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output v4mu_pkg::t_out_word  o_res
);
    localparam int SQ = v4mu_pkg::SQRT_STEPS;
    localparam int DV = v4mu_pkg::DIV_STEPS;
    localparam int LAT = 3 + SQ + DV;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        scal;
        logic               fault;
    } t_side;

    logic [LAT-1:0] r_vld;
    logic [63:0]        sq [4];
    logic signed [63:0] ab [4];
    logic signed [63:0] cd [4];
    logic signed [31:0] av [4];
    logic signed [31:0] bv [4];
    logic signed [31:0] cv [4];
    logic signed [31:0] dv [4];
    logic [1:0]         r_func1;
    logic               r_wnz1;
    logic signed [31:0] r_a1 [4];
    logic signed [63:0] r_ef [4];

    assign av = '{i_cmd.a_x, i_cmd.a_y, i_cmd.a_z, i_cmd.a_w};
    assign bv = '{i_cmd.b_x, i_cmd.b_y, i_cmd.b_z, i_cmd.b_w};
    // Cross terms per lane: x: ay*bz - az*by, y: az*bx - ax*bz, z: ax*by - ay*bx.
    assign cv = '{i_cmd.a_y, i_cmd.a_z, i_cmd.a_x, 32'sd0};
    assign dv = '{i_cmd.b_z, i_cmd.b_x, i_cmd.b_y, 32'sd0};

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            logic signed [31:0] n_e;
            logic signed [31:0] n_f;
            assign n_e = (g == 0) ? i_cmd.a_z : (g == 1) ? i_cmd.a_x :
                         (g == 2) ? i_cmd.a_y : 32'sd0;
            assign n_f = (g == 0) ? i_cmd.b_y : (g == 1) ? i_cmd.b_z :
                         (g == 2) ? i_cmd.b_x : 32'sd0;
            v4mu_lane u_lane (
                .i_clk(i_clk), .i_a(av[g]), .i_b(bv[g]),
                .i_c(g == 3 ? 32'sd0 : cv[g]), .i_d(g == 3 ? 32'sd0 : dv[g]),
                .o_sq(sq[g]), .o_ab(ab[g]), .o_cd(cd[g])
            );
            // Second cross product of the lane shares the stage.
            always_ff @(posedge i_clk) begin
                r_ef[g] <= n_e * n_f;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_func1 <= i_cmd.func;
        r_wnz1  <= (i_cmd.a_w != 32'sd0) || (i_cmd.b_w != 32'sd0);
        r_a1    <= '{i_cmd.a_x, i_cmd.a_y, i_cmd.a_z, i_cmd.a_w};
    end

    // Merge stage: sum of squares, dot and cross, with saturation.
    logic [64:0]        n_ssum;
    logic signed [67:0] n_dot;
    logic [31:0]        n_cr [3];
    always_comb begin
        n_ssum = {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]} + {1'b0, sq[3]};
        n_dot  = (68'(ab[0]) + 68'(ab[1]) + 68'(ab[2]) + 68'(ab[3])) >>> FRAC_BITS;
        for (int k = 0; k < 3; k++) begin
            n_cr[k] = v4mu_pkg::sat32((68'(cd[k]) - 68'(r_ef[k])) >>> FRAC_BITS);
        end
    end

    t_side               n_side;
    always_comb begin
        n_side       = '0;
        n_side.func  = r_func1;
        n_side.fault = 1'b0;
        if (r_func1 == v4mu_pkg::FUNC_DOT) begin
            n_side.scal = v4mu_pkg::sat32(n_dot);
        end else if (r_func1 == v4mu_pkg::FUNC_CROSS) begin
            n_side.fault = r_wnz1;
            if (!r_wnz1) begin
                n_side.x = n_cr[0];
                n_side.y = n_cr[1];
                n_side.z = n_cr[2];
            end
        end
    end

    // Side data travels alongside the root and divider pipelines.
    t_side r_side [SQ+1];
    t_side r_dside [DV];
    logic signed [31:0] r_ac [SQ+1][4];

    // Root pipeline.
    logic [65:0] s_rem  [SQ+1];
    logic [32:0] s_root [SQ+1];
    logic [64:0] s_n    [SQ+1];
    logic [64:0] r_n0;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        r_ac[0]   <= r_a1;
    end
    assign s_n[0] = r_n0;
    always_ff @(posedge i_clk) begin
        r_n0 <= n_ssum;
    end

    generate
        for (g = 0; g < SQ; g++) begin : g_sq
            v4mu_sqrt_stage #(.STEP(g)) u_st (
                .i_clk(i_clk), .i_rem(s_rem[g]), .i_root(s_root[g]), .i_n(s_n[g]),
                .o_rem(s_rem[g+1]), .o_root(s_root[g+1]), .o_n(s_n[g+1])
            );
            always_ff @(posedge i_clk) begin
                r_side[g+1] <= r_side[g];
                r_ac[g+1]   <= r_ac[g];
            end
        end
    endgenerate

    // Magnitude known: fix scalar and fault, start four divider lanes.
    logic [32:0] w_mag;
    t_side       n_side2;
    assign w_mag = s_root[SQ];
    always_comb begin
        n_side2 = r_side[SQ];
        if (r_side[SQ].func == v4mu_pkg::FUNC_MAG ||
            r_side[SQ].func == v4mu_pkg::FUNC_NORM) begin
            n_side2.scal = (w_mag[32] || w_mag[31]) ? 32'h7FFF_FFFF : w_mag[31:0];
            if (r_side[SQ].func == v4mu_pkg::FUNC_NORM && w_mag == '0) begin
                n_side2.fault = 1'b1;
                n_side2.scal  = '0;
            end
        end
    end

    logic [DV-1:0] r_neg [4];
    logic [31:0] n_wr  [4];
    logic        w_div_use;
    assign w_div_use = (r_dside[DV-1].func == v4mu_pkg::FUNC_NORM) && !r_dside[DV-1].fault;

    generate
        for (g = 0; g < 4; g++) begin : g_div
            logic [56:0] d_rem [DV+1];
            logic [55:0] d_q   [DV+1];
            logic [55:0] d_num [DV+1];
            logic [32:0] d_den [DV+1];
            logic [31:0] w_m;
            logic [55:0] q;
            assign w_m = r_ac[SQ][g][31] ? 32'(-r_ac[SQ][g]) : r_ac[SQ][g];
            assign d_rem[0] = '0;
            assign d_q[0]   = '0;
            assign d_num[0] = 56'({24'd0, w_m} << FRAC_BITS);
            assign d_den[0] = (w_mag == '0) ? 33'd1 : w_mag;
            always_ff @(posedge i_clk) begin
                r_neg[g][0] <= r_ac[SQ][g][31];
            end
            for (genvar s = 0; s < DV; s++) begin : g_st
                v4mu_div_stage #(.STEP(s)) u_dv (
                    .i_clk(i_clk), .i_rem(d_rem[s]), .i_q(d_q[s]), .i_num(d_num[s]),
                    .i_den(d_den[s]), .o_rem(d_rem[s+1]), .o_q(d_q[s+1]),
                    .o_num(d_num[s+1]), .o_den(d_den[s+1])
                );
                if (s < DV - 1) begin : g_ng
                    always_ff @(posedge i_clk) begin
                        r_neg[g][s+1] <= r_neg[g][s];
                    end
                end
            end
            assign q = d_q[DV];
            // Signed saturation of the quotient.
            always_comb begin
                if (r_neg[g][DV-1]) begin
                    n_wr[g] = (q > 56'h8000_0000) ? 32'h8000_0000 : 32'(-q);
                end else begin
                    n_wr[g] = (q > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                end
            end
        end
    endgenerate

    // Side data beside the divider pipeline.
    always_ff @(posedge i_clk) begin
        r_dside[0] <= n_side2;
        for (int k = 1; k < DV; k++) begin
            r_dside[k] <= r_dside[k-1];
        end
    end

    // Output register.
    v4mu_pkg::t_out_word r_res;
    always_ff @(posedge i_clk) begin
        r_res.res_x      <= w_div_use ? n_wr[0] : r_dside[DV-1].x;
        r_res.res_y      <= w_div_use ? n_wr[1] : r_dside[DV-1].y;
        r_res.res_z      <= w_div_use ? n_wr[2] : r_dside[DV-1].z;
        r_res.res_w      <= w_div_use ? n_wr[3] : 32'sd0;
        r_res.res_scalar <= r_dside[DV-1].scal;
        r_res.fault      <= r_dside[DV-1].fault;
    end

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[LAT-1];
    assign o_res  = r_res;
endmodule

// ===== sv/v4mu_checker.sv =====
module v4mu_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_done,
    input v4mu_pkg::t_out_word o_res
);
    // The unit never refuses a word.
    a_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    // A faulting result carries zero x and w components.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.fault |-> o_res.res_x == 0 && o_res.res_w == 0)
        else $error("fault with tuple");
    // Each strobe needs a matching earlier start.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 92))
        else $error("result without command");
endmodule

bind vector4_math_unit v4mu_props u_v4mu_props (.*);
